// ===== design/kvt_pkg.sv =====
// ============================================================================
// kvt_pkg
// Shared types and codes of the key-value table with swap delete.
// ============================================================================
`default_nettype none

package kvt_pkg;

    // One request transaction.
    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } kvt_req_t;

    // One result transaction.
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] read_value;
    } kvt_resp_t;

    // One stored entry of the table memory.
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
    } kvt_entry_t;

    // Request types.
    localparam logic [1:0] REQ_SET = 2'd0;
    localparam logic [1:0] REQ_GET = 2'd1;
    localparam logic [1:0] REQ_DEL = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UNCHANGED = 3'd1;
    localparam logic [2:0] ST_UPDATED   = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_DELETED   = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    // Datapath actions selected by the control word.
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_LATCH     = 3'd1;
    localparam logic [2:0] ACT_SCAN      = 3'd2;
    localparam logic [2:0] ACT_APPEND    = 3'd3;
    localparam logic [2:0] ACT_UPDATE    = 3'd4;
    localparam logic [2:0] ACT_READ_LAST = 3'd5;
    localparam logic [2:0] ACT_MOVE      = 3'd6;

    // Conditions that the sequencer can test.
    localparam logic [3:0] COND_NEVER     = 4'd0;
    localparam logic [3:0] COND_ALWAYS    = 4'd1;
    localparam logic [3:0] COND_NOT_START = 4'd2;
    localparam logic [3:0] COND_HIT       = 4'd3;
    localparam logic [3:0] COND_SCAN_MORE = 4'd4;
    localparam logic [3:0] COND_NOT_SET   = 4'd5;
    localparam logic [3:0] COND_FULL      = 4'd6;
    localparam logic [3:0] COND_IS_GET    = 4'd7;
    localparam logic [3:0] COND_IS_DEL    = 4'd8;
    localparam logic [3:0] COND_VAL_EQ    = 4'd9;

    localparam int STEP_W = 4;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic start;
        logic hit;
        logic scan_more;
        logic is_set;
        logic is_get;
        logic is_del;
        logic full;
        logic val_eq;
    } kvt_flags_t;

    // One microcode control word.
    typedef struct packed {
        logic [2:0]        act;
        logic              emit;
        logic [2:0]        status;
        logic [3:0]        br_cond;
        logic [STEP_W-1:0] br_target;
        logic [3:0]        wait_cond;
    } kvt_ctrl_t;

endpackage

`default_nettype wire

// ===== design/key_value_table_swap_delete_core.sv =====
// ============================================================================
// key_value_table_swap_delete_core
// Dense key-value table with swap delete, run by a microcoded sequencer.
// ============================================================================
// The key scan reads one entry per cycle from the one-port memory, so a request takes longer
// the further into the table its key sits, and a miss scans every live entry first. The
// slowest request is a set hitting the last slot.
// Throughput: one request at a time; busy is low again in the strobe cycle.
// Reset clears the step counter and the entry count; the entry memory is not cleared.
`default_nettype none

module key_value_table_swap_delete_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire kvt_pkg::kvt_req_t req,
    output logic                   busy,
    output logic                   result_valid,
    output kvt_pkg::kvt_resp_t     result
);

    // Address width indexes the memory; count width can also hold the depth.
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    kvt_pkg::kvt_ctrl_t  ctrl;
    kvt_pkg::kvt_flags_t flags;

    // Latched request transaction.
    kvt_pkg::kvt_req_t req_reg;
    kvt_pkg::kvt_req_t req_next;

    // Number of live entries; they always sit packed in slots below it.
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] count_m1;

    // Scan state. The memory read data is registered and arrives in the cycle after its read address,
    // so cmp_valid_reg marks that rdata_reg holds the entry at cmp_idx_reg.
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [AW-1:0] cmp_idx_reg;
    logic [AW-1:0] cmp_idx_next;
    logic          cmp_valid_reg;
    logic          cmp_valid_next;
    logic          cmp_hit;

    // Slot and stored value of the matching entry.
    logic [AW-1:0] hit_slot_reg;
    logic [AW-1:0] hit_slot_next;
    logic [31:0]   hit_value_reg;
    logic [31:0]   hit_value_next;

    // Single-port entry memory.
    kvt_pkg::kvt_entry_t entries_mem [TABLE_DEPTH];
    kvt_pkg::kvt_entry_t rdata_reg;
    kvt_pkg::kvt_entry_t wdata;
    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    logic                mem_re;

    // Result register.
    logic               result_valid_reg;
    kvt_pkg::kvt_resp_t result_reg;

    kvt_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    assign count_m1 = count_reg - CW'(1);
    assign cmp_hit  = cmp_valid_reg && (rdata_reg.key == req_reg.key);

    always_comb
    begin
        flags.start     = start;
        flags.hit       = cmp_hit;
        flags.scan_more = (idx_reg < count_reg) || cmp_valid_reg;
        flags.is_set    = (req_reg.req_type == kvt_pkg::REQ_SET);
        flags.is_get    = (req_reg.req_type == kvt_pkg::REQ_GET);
        flags.is_del    = (req_reg.req_type == kvt_pkg::REQ_DEL);
        flags.full      = (count_reg == CW'(TABLE_DEPTH));
        flags.val_eq    = (hit_value_reg == req_reg.value);
    end

    // Datapath actions of the current control word.
    always_comb
    begin
        req_next       = req_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        hit_slot_next  = hit_slot_reg;
        hit_value_next = hit_value_reg;
        mem_addr       = idx_reg[AW-1:0];
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        wdata          = rdata_reg;
        case (ctrl.act)
            kvt_pkg::ACT_LATCH:
            begin
                if (start)
                begin
                    req_next       = req;
                    idx_next       = '0;
                    cmp_valid_next = 1'b0;
                end
            end
            kvt_pkg::ACT_SCAN:
            begin
                if (cmp_hit)
                begin
                    hit_slot_next  = cmp_idx_reg;
                    hit_value_next = rdata_reg.value;
                    cmp_valid_next = 1'b0;
                end
                else if (idx_reg < count_reg)
                begin
                    mem_re         = 1'b1;
                    mem_addr       = idx_reg[AW-1:0];
                    cmp_idx_next   = idx_reg[AW-1:0];
                    cmp_valid_next = 1'b1;
                    idx_next       = idx_reg + CW'(1);
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
            end
            kvt_pkg::ACT_APPEND:
            begin
                mem_we      = 1'b1;
                mem_addr    = count_reg[AW-1:0];
                wdata.key   = req_reg.key;
                wdata.value = req_reg.value;
                count_next  = count_reg + CW'(1);
            end
            kvt_pkg::ACT_UPDATE:
            begin
                mem_we      = 1'b1;
                mem_addr    = hit_slot_reg;
                wdata.key   = req_reg.key;
                wdata.value = req_reg.value;
            end
            kvt_pkg::ACT_READ_LAST:
            begin
                mem_re   = 1'b1;
                mem_addr = count_m1[AW-1:0];
            end
            kvt_pkg::ACT_MOVE:
            begin
                // The last entry fills the freed slot; a delete of the last
                // entry rewrites that slot with itself.
                mem_we     = 1'b1;
                mem_addr   = hit_slot_reg;
                wdata      = rdata_reg;
                count_next = count_m1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entries_mem[mem_addr] <= wdata;
        end
        else if (mem_re)
        begin
            rdata_reg <= entries_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            idx_reg          <= '0;
            cmp_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            cmp_valid_reg    <= cmp_valid_next;
            result_valid_reg <= ctrl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_slot_reg  <= hit_slot_next;
        hit_value_reg <= hit_value_next;
        if (ctrl.emit)
        begin
            result_reg.status <= ctrl.status;
            if (ctrl.status == kvt_pkg::ST_FOUND)
            begin
                result_reg.read_value <= hit_value_reg;
            end
            else
            begin
                result_reg.read_value <= '0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== design/kvt_sequencer.sv =====
// ============================================================================
// kvt_sequencer
// Microcode store and step counter that steer the table datapath.
// ============================================================================
`default_nettype none

module kvt_sequencer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kvt_pkg::kvt_flags_t flags,
    output kvt_pkg::kvt_ctrl_t      ctrl,
    output logic                    busy
);

    // Program step addresses.
    localparam logic [kvt_pkg::STEP_W-1:0] S_IDLE     = 4'd0;
    localparam logic [kvt_pkg::STEP_W-1:0] S_SCAN     = 4'd1;
    localparam logic [kvt_pkg::STEP_W-1:0] S_MISS     = 4'd2;
    localparam logic [kvt_pkg::STEP_W-1:0] S_INS_CHK  = 4'd3;
    localparam logic [kvt_pkg::STEP_W-1:0] S_APPEND   = 4'd4;
    localparam logic [kvt_pkg::STEP_W-1:0] S_NF       = 4'd5;
    localparam logic [kvt_pkg::STEP_W-1:0] S_FULLR    = 4'd6;
    localparam logic [kvt_pkg::STEP_W-1:0] S_HIT      = 4'd7;
    localparam logic [kvt_pkg::STEP_W-1:0] S_HIT_DEL  = 4'd8;
    localparam logic [kvt_pkg::STEP_W-1:0] S_HIT_SET  = 4'd9;
    localparam logic [kvt_pkg::STEP_W-1:0] S_SET_CHK  = 4'd10;
    localparam logic [kvt_pkg::STEP_W-1:0] S_UPDATE   = 4'd11;
    localparam logic [kvt_pkg::STEP_W-1:0] S_GETR     = 4'd12;
    localparam logic [kvt_pkg::STEP_W-1:0] S_UNCH     = 4'd13;
    localparam logic [kvt_pkg::STEP_W-1:0] S_DEL_RD   = 4'd14;
    localparam logic [kvt_pkg::STEP_W-1:0] S_DEL_WR   = 4'd15;

    // Increment of the step counter.
    localparam logic [kvt_pkg::STEP_W-1:0] STEP_ONE   = 4'd1;

    logic [kvt_pkg::STEP_W-1:0] pc_reg;
    logic [kvt_pkg::STEP_W-1:0] pc_next;
    logic                       br_taken;
    logic                       wait_hold;

    function automatic kvt_pkg::kvt_ctrl_t cw(
        input logic [2:0]                 act,
        input logic                       emit,
        input logic [2:0]                 status,
        input logic [3:0]                 br_cond,
        input logic [kvt_pkg::STEP_W-1:0] br_target,
        input logic [3:0]                 wait_cond
    );
        kvt_pkg::kvt_ctrl_t w;
        w.act       = act;
        w.emit      = emit;
        w.status    = status;
        w.br_cond   = br_cond;
        w.br_target = br_target;
        w.wait_cond = wait_cond;
        return w;
    endfunction

    function automatic logic cond_true(
        input logic [3:0]          code,
        input kvt_pkg::kvt_flags_t f
    );
        logic r;
        case (code)
            kvt_pkg::COND_NEVER:     r = 1'b0;
            kvt_pkg::COND_ALWAYS:    r = 1'b1;
            kvt_pkg::COND_NOT_START: r = !f.start;
            kvt_pkg::COND_HIT:       r = f.hit;
            kvt_pkg::COND_SCAN_MORE: r = f.scan_more;
            kvt_pkg::COND_NOT_SET:   r = !f.is_set;
            kvt_pkg::COND_FULL:      r = f.full;
            kvt_pkg::COND_IS_GET:    r = f.is_get;
            kvt_pkg::COND_IS_DEL:    r = f.is_del;
            kvt_pkg::COND_VAL_EQ:    r = f.val_eq;
            default:                 r = 1'b0;
        endcase
        return r;
    endfunction

    // Program store: one control word per step.
    always_comb
    begin
        case (pc_reg)
            S_IDLE:    ctrl = cw(kvt_pkg::ACT_LATCH, 1'b0, kvt_pkg::ST_NOT_FOUND,
                                 kvt_pkg::COND_NEVER, S_IDLE, kvt_pkg::COND_NOT_START);
            S_SCAN:    ctrl = cw(kvt_pkg::ACT_SCAN, 1'b0, kvt_pkg::ST_NOT_FOUND,
                                 kvt_pkg::COND_HIT, S_HIT, kvt_pkg::COND_SCAN_MORE);
            S_MISS:    ctrl = cw(kvt_pkg::ACT_NONE, 1'b0, kvt_pkg::ST_NOT_FOUND,
                                 kvt_pkg::COND_NOT_SET, S_NF, kvt_pkg::COND_NEVER);
            S_INS_CHK: ctrl = cw(kvt_pkg::ACT_NONE, 1'b0, kvt_pkg::ST_NOT_FOUND,
                                 kvt_pkg::COND_FULL, S_FULLR, kvt_pkg::COND_NEVER);
            S_APPEND:  ctrl = cw(kvt_pkg::ACT_APPEND, 1'b1, kvt_pkg::ST_INSERTED,
                                 kvt_pkg::COND_ALWAYS, S_IDLE, kvt_pkg::COND_NEVER);
            S_NF:      ctrl = cw(kvt_pkg::ACT_NONE, 1'b1, kvt_pkg::ST_NOT_FOUND,
                                 kvt_pkg::COND_ALWAYS, S_IDLE, kvt_pkg::COND_NEVER);
            S_FULLR:   ctrl = cw(kvt_pkg::ACT_NONE, 1'b1, kvt_pkg::ST_FULL,
                                 kvt_pkg::COND_ALWAYS, S_IDLE, kvt_pkg::COND_NEVER);
            S_HIT:     ctrl = cw(kvt_pkg::ACT_NONE, 1'b0, kvt_pkg::ST_NOT_FOUND,
                                 kvt_pkg::COND_IS_GET, S_GETR, kvt_pkg::COND_NEVER);
            S_HIT_DEL: ctrl = cw(kvt_pkg::ACT_NONE, 1'b0, kvt_pkg::ST_NOT_FOUND,
                                 kvt_pkg::COND_IS_DEL, S_DEL_RD, kvt_pkg::COND_NEVER);
            S_HIT_SET: ctrl = cw(kvt_pkg::ACT_NONE, 1'b0, kvt_pkg::ST_NOT_FOUND,
                                 kvt_pkg::COND_NOT_SET, S_NF, kvt_pkg::COND_NEVER);
            S_SET_CHK: ctrl = cw(kvt_pkg::ACT_NONE, 1'b0, kvt_pkg::ST_NOT_FOUND,
                                 kvt_pkg::COND_VAL_EQ, S_UNCH, kvt_pkg::COND_NEVER);
            S_UPDATE:  ctrl = cw(kvt_pkg::ACT_UPDATE, 1'b1, kvt_pkg::ST_UPDATED,
                                 kvt_pkg::COND_ALWAYS, S_IDLE, kvt_pkg::COND_NEVER);
            S_GETR:    ctrl = cw(kvt_pkg::ACT_NONE, 1'b1, kvt_pkg::ST_FOUND,
                                 kvt_pkg::COND_ALWAYS, S_IDLE, kvt_pkg::COND_NEVER);
            S_UNCH:    ctrl = cw(kvt_pkg::ACT_NONE, 1'b1, kvt_pkg::ST_UNCHANGED,
                                 kvt_pkg::COND_ALWAYS, S_IDLE, kvt_pkg::COND_NEVER);
            S_DEL_RD:  ctrl = cw(kvt_pkg::ACT_READ_LAST, 1'b0, kvt_pkg::ST_NOT_FOUND,
                                 kvt_pkg::COND_NEVER, S_IDLE, kvt_pkg::COND_NEVER);
            S_DEL_WR:  ctrl = cw(kvt_pkg::ACT_MOVE, 1'b1, kvt_pkg::ST_DELETED,
                                 kvt_pkg::COND_ALWAYS, S_IDLE, kvt_pkg::COND_NEVER);
            default:   ctrl = cw(kvt_pkg::ACT_NONE, 1'b0, kvt_pkg::ST_NOT_FOUND,
                                 kvt_pkg::COND_ALWAYS, S_IDLE, kvt_pkg::COND_NEVER);
        endcase
    end

    // A taken branch wins; otherwise a true wait condition holds the step.
    always_comb
    begin
        br_taken  = cond_true(ctrl.br_cond, flags);
        wait_hold = cond_true(ctrl.wait_cond, flags);
        if (br_taken)
        begin
            pc_next = ctrl.br_target;
        end
        else if (wait_hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + STEP_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign busy = (pc_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== design/kvt_checker.sv =====
// ============================================================================
// kvt_checker
// Port-level checks of the key-value table core, bound to the top level.
// ============================================================================
`default_nettype none

module kvt_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               result_valid,
    input wire kvt_pkg::kvt_resp_t result
);

    // An accepted request keeps the core busy in the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after an accepted request");

    // The core goes idle exactly as the result is strobed.
    a_fall_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("core went idle without a result");

    // A result is strobed once and only while the core is idle.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!busy && !$past(result_valid)))
        else $error("result strobe repeated or shown while busy");

    // Only a found result carries a stored value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != kvt_pkg::ST_FOUND)) |->
            (result.read_value == '0))
        else $error("nonzero read value on a result other than found");

endmodule

bind key_value_table_swap_delete_core kvt_checker u_kvt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

// ===== dv/kvt_table_checker.sv =====
// ============================================================================
// kvt_table_checker
// Watches the request and result channels of the key-value table, keeps a
// shadow copy of the table, and compares every result against it.
// ============================================================================

module kvt_table_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  kvt_pkg::kvt_req_t  req,
    input  logic               result_valid,
    input  kvt_pkg::kvt_resp_t result,
    output int                 fail_count,
    output int                 pending_results
);
    import kvt_pkg::*;

    logic [31:0] shadow_keys   [TABLE_DEPTH];
    logic [31:0] shadow_values [TABLE_DEPTH];
    int          shadow_count;
    kvt_resp_t   expected_responses [$];

    initial
    begin
        fail_count      = 0;
        pending_results = 0;
        shadow_count    = 0;
    end

    // Applies one request to the shadow table and returns the response it must give.
    function automatic kvt_resp_t apply_request(input kvt_req_t r);
        kvt_resp_t rsp;
        int        slot;
        rsp.status     = ST_NOT_FOUND;
        rsp.read_value = '0;
        slot           = -1;
        for (int i = 0; i < shadow_count; i++)
        begin
            if (slot < 0 && shadow_keys[i] == r.key)
                slot = i;
        end
        case (r.req_type)
            REQ_SET:
            begin
                if (slot >= 0)
                begin
                    if (shadow_values[slot] == r.value)
                        rsp.status = ST_UNCHANGED;
                    else
                    begin
                        shadow_values[slot] = r.value;
                        rsp.status          = ST_UPDATED;
                    end
                end
                else if (shadow_count >= TABLE_DEPTH)
                    rsp.status = ST_FULL;
                else
                begin
                    shadow_keys[shadow_count]   = r.key;
                    shadow_values[shadow_count] = r.value;
                    shadow_count++;
                    rsp.status = ST_INSERTED;
                end
            end
            REQ_GET:
            begin
                if (slot >= 0)
                begin
                    rsp.status     = ST_FOUND;
                    rsp.read_value = shadow_values[slot];
                end
            end
            REQ_DEL:
            begin
                if (slot >= 0)
                begin
                    shadow_keys[slot]   = shadow_keys[shadow_count - 1];
                    shadow_values[slot] = shadow_values[shadow_count - 1];
                    shadow_count--;
                    rsp.status = ST_DELETED;
                end
            end
            default:
            begin
            end
        endcase
        return rsp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kvt_resp_t want;
        if (!rst_n)
        begin
            expected_responses.delete();
            shadow_count = 0;
            pending_results <= 0;
        end
        else
        begin
            // A result leaving at this edge belongs to the older transaction, so it
            // is checked before a request accepted at the same edge is predicted.
            if (result_valid)
            begin
                if (expected_responses.size() == 0)
                begin
                    $error("unexpected result: status %0d, read_value %0d",
                           result.status, result.read_value);
                    fail_count++;
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, result.status);
                        fail_count++;
                    end
                    if (result.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, actual %0d",
                               want.read_value, result.read_value);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_responses = {expected_responses, apply_request(req)};
            pending_results <= expected_responses.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// ============================================================================
// testbench
// Drives requests into the key-value table and gives the verdict.
// A directed sequence covers the field extremes and every status but full, then random
// phases with different key pools and request mixes fill, churn and drain the
// table while the sender idles at different rates.
// ============================================================================

module testbench;
    import kvt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    // The one request code that the block ignores.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // Longest stretch without any accepted transaction: far longer than a full scan
    // or the longest sender gap, so this leaves a wide margin.
    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int POOL_SIZE = 80;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      start        = 1'b0;
    kvt_req_t  req          = '0;
    logic      busy;
    logic      result_valid;
    kvt_resp_t result;

    int fail_count;
    int pending_results;
    int quiet_cycles = 0;

    // Keys that the random phases draw from, and the value last written to each,
    // so that some sets repeat a stored value and give the unchanged status.
    logic [31:0] key_pool   [POOL_SIZE];
    logic [31:0] last_value [POOL_SIZE];
    int          sweep_index = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    key_value_table_swap_delete_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req         (req),
        .busy        (busy),
        .result_valid(result_valid),
        .result      (result)
    );

    kvt_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req            (req),
        .result_valid   (result_valid),
        .result         (result),
        .fail_count     (fail_count),
        .pending_results(pending_results)
    );

    // The watchdog counts cycles in which neither a request nor a result
    // transaction is accepted, and ends the run if the block hangs.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic kvt_req_t make_req(input logic [1:0] kind, input logic [31:0] k,
                                          input logic [31:0] v);
        kvt_req_t r;
        r.req_type = kind;
        r.key      = k;
        r.value    = v;
        return r;
    endfunction

    // Holds start high until the block takes the transaction. Start is left high
    // on return, so a request that follows at once keeps it asserted.
    task automatic send_request(input kvt_req_t r);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Sender gap: start goes low and the request bus carries noise meanwhile.
    task automatic idle_sender(input int cycles);
        start <= 1'b0;
        req   <= make_req(2'($urandom), $urandom, $urandom);
        repeat (cycles) @(posedge clk);
    endtask

    // The sender holds off until every predicted result has come back. The first
    // edge is always waited for, since the count is a registered copy of the queue size.
    task automatic wait_for_drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    // One random request. Keys mostly come from the first pool_size pool entries
    // so that hits are common; one in ten is a fresh random key. With sweep set,
    // most sets walk the pool in order, which pushes the table to full.
    function automatic kvt_req_t make_random_req(input int pool_size, input int set_pct,
                                                 input int get_pct, input int del_pct,
                                                 input bit sweep);
        kvt_req_t r;
        int       roll;
        int       idx;
        roll = $urandom_range(0, 99);
        if (roll < set_pct)
            r.req_type = REQ_SET;
        else if (roll < set_pct + get_pct)
            r.req_type = REQ_GET;
        else if (roll < set_pct + get_pct + del_pct)
            r.req_type = REQ_DEL;
        else
            r.req_type = REQ_UNUSED;
        if (sweep && r.req_type == REQ_SET && $urandom_range(0, 9) < 7)
        begin
            idx = sweep_index % pool_size;
            sweep_index++;
        end
        else
            idx = $urandom_range(0, pool_size - 1);
        r.key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[idx];
        case ($urandom_range(0, 3))
            0:       r.value = last_value[idx];
            1:       r.value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: r.value = $urandom;
        endcase
        if (r.req_type == REQ_SET && r.key == key_pool[idx])
            last_value[idx] = r.value;
        return r;
    endfunction

    // One random phase. Ignored requests do not count toward the phase length.
    // Now and then the sender waits for the table to go quiet before going on.
    task automatic run_phase(input int pool_size, input int set_pct, input int get_pct,
                             input int del_pct, input bit sweep, input int idle_pct);
        kvt_req_t r;
        int       counted;
        counted = 0;
        while (counted < ITEMS_PER_PHASE)
        begin
            r = make_random_req(pool_size, set_pct, get_pct, del_pct, sweep);
            send_request(r);
            if (r.req_type != REQ_UNUSED)
                counted++;
            if ($urandom_range(0, 49) == 0)
                wait_for_drain();
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                // Mostly short gaps, with some long enough to span a full scan.
                if ($urandom_range(0, 3) == 0)
                    idle_sender($urandom_range(5, 90));
                else
                    idle_sender($urandom_range(1, 4));
            end
        end
        wait_for_drain();
    endtask

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i]   = $urandom;
            last_value[i] = $urandom;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, back to back. Lookups on the empty table come first.
        send_request(make_req(REQ_GET, 32'h8000_0000, 32'h0));
        send_request(make_req(REQ_DEL, 32'h8000_0000, 32'h0));
        // Inserts with the extreme keys and values.
        send_request(make_req(REQ_SET, 32'h8000_0000, 32'h7fff_ffff));
        send_request(make_req(REQ_SET, 32'h7fff_ffff, 32'h8000_0000));
        send_request(make_req(REQ_SET, 32'h0000_0000, 32'h0000_0000));
        send_request(make_req(REQ_SET, 32'hffff_ffff, 32'hffff_ffff));
        // Same value again is unchanged; a new value is an update.
        send_request(make_req(REQ_SET, 32'h8000_0000, 32'h7fff_ffff));
        send_request(make_req(REQ_SET, 32'h8000_0000, 32'h0000_0000));
        send_request(make_req(REQ_GET, 32'h8000_0000, 32'hffff_ffff));
        send_request(make_req(REQ_GET, 32'h7fff_ffff, 32'h0));
        send_request(make_req(REQ_GET, 32'hffff_ffff, 32'h0));
        send_request(make_req(REQ_GET, 32'h0000_1234, 32'h0));
        // The unused request code must leave the table alone.
        send_request(make_req(REQ_UNUSED, 32'h0000_0000, 32'h0000_0005));
        send_request(make_req(REQ_UNUSED, 32'hffff_ffff, 32'hffff_ffff));
        // Deleting a middle entry moves the last one into its slot.
        send_request(make_req(REQ_DEL, 32'h7fff_ffff, 32'h0));
        send_request(make_req(REQ_GET, 32'hffff_ffff, 32'h0));
        send_request(make_req(REQ_DEL, 32'hffff_ffff, 32'h0));
        // Key zero now sits in the last slot, so this deletes the last entry.
        send_request(make_req(REQ_DEL, 32'h0000_0000, 32'h0));
        send_request(make_req(REQ_DEL, 32'h0000_0000, 32'h0));
        send_request(make_req(REQ_GET, 32'h8000_0000, 32'h0));
        send_request(make_req(REQ_DEL, 32'h8000_0000, 32'h0));
        send_request(make_req(REQ_GET, 32'h8000_0000, 32'h0));
        wait_for_drain();

        // Small pool and no idling: lots of hits, updates and swap deletes.
        run_phase(12, 45, 35, 15, 1'b0, 0);
        // Large pool, set heavy with a sweep: the table fills and sets see it full.
        run_phase(70, 80, 12, 6, 1'b1, 50);
        // Delete heavy phase drains the table again. The receiver cannot stall
        // results, so this phase runs without idling.
        run_phase(70, 25, 25, 48, 1'b0, 0);
        // Mixed traffic with light idling.
        run_phase(24, 40, 30, 28, 1'b0, 19);

        // Let any trailing activity show up before the verdict.
        repeat (TABLE_DEPTH + 10) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
